// File: sv/fwmpe_pkg.sv
package fwmpe_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int FIELD_W      = 32;
    localparam int ENTRY_W      = 2 * FIELD_W;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_EXT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] prio;
        logic signed [FIELD_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [1:0] status;
        entry_t     entry;
    } result_t;

endpackage

// File: sv/fwmpe_ram.sv
module fwmpe_ram #(
    parameter int WIDTH = fwmpe_pkg::ENTRY_W,
    parameter int DEPTH = fwmpe_pkg::CAPACITY_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/fwmpe_out.sv
module fwmpe_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwmpe_pkg::result_t  in_res,
    output logic                out_valid,
    input  logic                out_ready,
    output fwmpe_pkg::result_t  out_res
);

    logic               valid_reg;
    fwmpe_pkg::result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

endmodule

// File: sv/fwmpe_ctrl.sv
module fwmpe_ctrl #(
    parameter int CAPACITY = fwmpe_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_op,
    input  fwmpe_pkg::entry_t            in_entry,
    output logic                         res_valid,
    input  logic                         res_ready,
    output fwmpe_pkg::result_t           res,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [fwmpe_pkg::ENTRY_W-1:0] ram_wdata,
    output logic [AW-1:0]                ram_raddr,
    input  logic [fwmpe_pkg::ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      scan_end_reg, scan_end_next;
    logic               data_vld_reg, data_vld_next;
    logic [AW-1:0]      data_idx_reg, data_idx_next;
    logic [AW-1:0]      pos_reg, pos_next;
    fwmpe_pkg::entry_t  best_reg, best_next;
    fwmpe_pkg::result_t res_reg, res_next;

    fwmpe_pkg::entry_t  cand;
    logic               take;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;
    assign cand      = fwmpe_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        scan_end_next = scan_end_reg;
        data_vld_next = 1'b0;
        data_idx_next = data_idx_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = data_idx_reg - AW'(1);
        ram_wdata     = ram_rdata;
        ram_raddr     = rd_idx_reg[AW-1:0];
        take          = (data_idx_reg == '0) || ($signed(cand.prio) > $signed(best_reg.prio));

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        fwmpe_pkg::OP_ENQ:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_next   = '{status: fwmpe_pkg::ST_FULL, entry: '0};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = in_entry;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fwmpe_pkg::OP_DEQ, fwmpe_pkg::OP_EXT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{status: fwmpe_pkg::ST_EMPTY, entry: '0};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                scan_end_next = (in_op == fwmpe_pkg::OP_EXT) ? count_reg
                                                                             : CW'(1);
                                rd_idx_next   = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg < scan_end_reg)
                begin
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    data_vld_next = 1'b1;
                    data_idx_next = rd_idx_reg[AW-1:0];
                end
                if (data_vld_reg)
                begin
                    if (take)
                    begin
                        best_next = cand;
                        pos_next  = data_idx_reg;
                    end
                    if (CW'(data_idx_reg) == scan_end_reg - CW'(1))
                    begin
                        rd_idx_next = CW'(take ? data_idx_reg : pos_reg) + CW'(1);
                        state_next  = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // move each later entry down by one to close the gap
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    data_vld_next = 1'b1;
                    data_idx_next = rd_idx_reg[AW-1:0];
                end
                if (data_vld_reg)
                begin
                    ram_we = 1'b1;
                end
                else if (!(rd_idx_reg < count_reg))
                begin
                    count_next = count_reg - CW'(1);
                    res_next   = '{status: fwmpe_pkg::ST_OK, entry: best_reg};
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            scan_end_reg <= '0;
            data_vld_reg <= 1'b0;
            data_idx_reg <= '0;
            pos_reg      <= '0;
            best_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            scan_end_reg <= scan_end_next;
            data_vld_reg <= data_vld_next;
            data_idx_reg <= data_idx_next;
            pos_reg      <= pos_next;
            best_reg     <= best_next;
            res_reg      <= res_next;
        end
    end

endmodule

// File: sv/fifo_with_max_priority_extract.sv
// channel   dir  tuser          tdata
// s_axis    in   op [1:0]       item_value [31:0], item_priority [63:32]
// m_axis    out  status [1:0]   out_value [31:0], out_priority [63:32]
//
// enqueue writes the entry as it is taken and gives no result; a full store gives a FULL status result
// dequeue and extract hold off new transfers while they step through the n entries
// on the single read port of the entry memory (scan, then shift down)
// rst_n clears the entry count and control; entry memory is not cleared
// a result waits in the output register while the next transfer is taken
module fifo_with_max_priority_extract #(
    parameter int CAPACITY = fwmpe_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // item_value, item_priority
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_value, out_priority
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [fwmpe_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [fwmpe_pkg::ENTRY_W-1:0] ram_rdata;
    logic                          res_valid;
    logic                          res_ready;
    fwmpe_pkg::result_t            res;
    fwmpe_pkg::result_t            out_res;

    fwmpe_ram #(
        .WIDTH (fwmpe_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fwmpe_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_entry  (fwmpe_pkg::entry_t'(s_axis_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fwmpe_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.entry;
    assign m_axis_tuser = out_res.status;

    a_no_data_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != fwmpe_pkg::ST_OK)) |-> (m_axis_tdata == '0))
        else $error("failed status carries nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code");

    a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready &&
         ((s_axis_tuser == fwmpe_pkg::OP_DEQ) || (s_axis_tuser == fwmpe_pkg::OP_EXT)))
        |=> !s_axis_tready)
        else $error("removal did not hold off the next transfer");

    a_unused_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == 2'd3)) |=> s_axis_tready)
        else $error("unused op left the block busy");

endmodule
